// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising aclk outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising aclk outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsxbc_pkg.sv
// Package: types, constants and key schedule functions for the running-sum XOR cipher.
`timescale 1ns / 1ps

package rsxbc_pkg;

    localparam int LANE_W    = 16;
    localparam int NUM_LANES = 4;
    localparam int BLOCK_W   = LANE_W * NUM_LANES;
    localparam int SEED_W    = 32;

    localparam logic [SEED_W-1:0] KS_ADD0 = 32'h5D58_8B65;
    localparam logic [SEED_W-1:0] KS_SUB1 = 32'h359D_3E2A;
    localparam logic [SEED_W-1:0] KS_SUB2 = 32'h70E4_4324;
    localparam logic [SEED_W-1:0] KS_ADD3 = 32'h6C07_8965;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_BLOCK = 1'b1
    } func_t;

    // Per-lane control, shared by all lane units in a cycle.
    typedef struct packed {
        logic load;
        logic blk;
        logic encrypt;
    } lane_ctrl_t;

    typedef struct packed {
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
    } ks_ab_t;

    typedef struct packed {
        logic [SEED_W-1:0] c;
        logic [SEED_W-1:0] d;
    } ks_cd_t;

    // First half of the schedule: a and b, one adder deep each.
    function automatic ks_ab_t ks_first(input logic [SEED_W-1:0] seed);
        ks_ab_t r;
        r.a = seed ^ (seed + KS_ADD0);
        r.b = r.a ^ (seed - KS_SUB1);
        return r;
    endfunction

    // Second half: c and d from registered a and b.
    function automatic ks_cd_t ks_second(input ks_ab_t ab);
        ks_cd_t r;
        r.c = ab.b ^ (ab.a - KS_SUB2);
        r.d = r.c ^ (ab.b + KS_ADD3);
        return r;
    endfunction

endpackage

// File: rtl/rsxbc_lane.sv
// One 16-bit lane: key register, XOR and running-sum key update.
`timescale 1ns / 1ps

module rsxbc_lane
    import rsxbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lane_ctrl_t        ctrl,
    input  logic [LANE_W-1:0] load_key,
    input  logic [LANE_W-1:0] lane_in,
    output logic [LANE_W-1:0] lane_out,
    output logic [LANE_W-1:0] key_out
);

    logic [LANE_W-1:0] key_reg;
    logic [LANE_W-1:0] key_next;
    logic [LANE_W-1:0] plain;

    assign lane_out = lane_in ^ key_reg;
    assign plain    = ctrl.encrypt ? lane_in : lane_out;
    assign key_out  = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctrl.load) begin
            key_next = load_key;
        end else if (ctrl.blk) begin
            key_next = key_reg + plain;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

endmodule

// File: rtl/running_sum_xor_block_cipher_unit.sv
// Top level of the running-sum XOR block cipher: handshakes, pipeline and key lanes.
//
//  Channel | Direction | Ports                                  | Moves
//  --------+-----------+----------------------------------------+---------------------------
//  s_      | in        | s_valid s_ready s_func s_seed s_block_in | key load or block transaction
//  m_      | out       | m_valid m_ready m_block_out            | one result per block
//  cfg_    | in        | cfg_valid cfg_ready cfg_encrypt_mode   | mode register write
//
// Two stages: an input register (holds the block and the first half of the key
// schedule) and the result register. The lane keys update in the second stage,
// so one transaction is taken every cycle unless a block waits on a stalled result; a
// block's result is registered as it executes. Load transactions give no result.
// Synchronous active-low reset clears the valid flags, lane keys and the mode.
// A stalled result holds the result register; the input register still drains
// load transactions, and s_ready falls only when both stages are full.
`timescale 1ns / 1ps

module running_sum_xor_block_cipher_unit
    import rsxbc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [SEED_W-1:0]  s_seed,
    input  logic [BLOCK_W-1:0] s_block_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [BLOCK_W-1:0] m_block_out,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_encrypt_mode
);

    `include "assert_macros.svh"

    // Mode register; writes are always taken.
    logic encrypt_reg;
    logic encrypt_next;

    // Input stage.
    logic               in_valid_reg;
    logic               in_valid_next;
    func_t              in_func_reg;
    ks_ab_t             in_ab_reg;
    logic [BLOCK_W-1:0] in_blk_reg;

    // Result stage.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BLOCK_W-1:0] out_blk_reg;

    logic               s_fire;
    logic               out_free;
    logic               exec;
    logic               exec_blk;
    logic               exec_load;
    ks_cd_t             cd;
    logic [BLOCK_W-1:0] load_keys;
    logic [BLOCK_W-1:0] blk_out;
    logic [BLOCK_W-1:0] keys;
    lane_ctrl_t         lane_ctrl;

    assign cfg_ready = 1'b1;

    always_comb begin
        encrypt_next = encrypt_reg;
        if (cfg_valid) begin
            encrypt_next = cfg_encrypt_mode;
        end
    end

    // A load executes regardless of the result side; a block needs a free slot.
    assign out_free  = !out_valid_reg || m_ready;
    assign exec      = in_valid_reg && ((in_func_reg == FUNC_LOAD) || out_free);
    assign exec_blk  = exec && (in_func_reg == FUNC_BLOCK);
    assign exec_load = exec && (in_func_reg == FUNC_LOAD);
    assign s_ready   = !in_valid_reg || exec;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (exec_blk) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Second half of the key schedule; lane 0 takes c[15:0], lane 3 d[31:16].
    assign cd        = ks_second(in_ab_reg);
    assign load_keys = {cd.d, cd.c};

    assign lane_ctrl.load    = exec_load;
    assign lane_ctrl.blk     = exec_blk;
    assign lane_ctrl.encrypt = encrypt_reg;

    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        rsxbc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (lane_ctrl),
            .load_key (load_keys[j*LANE_W +: LANE_W]),
            .lane_in  (in_blk_reg[j*LANE_W +: LANE_W]),
            .lane_out (blk_out[j*LANE_W +: LANE_W]),
            .key_out  (keys[j*LANE_W +: LANE_W])
        );
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            encrypt_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            encrypt_reg   <= encrypt_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload; first half of the key schedule is done on the way in.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg <= func_t'(s_func);
            in_ab_reg   <= ks_first(s_seed);
            in_blk_reg  <= s_block_in;
        end
        if (exec_blk) begin
            out_blk_reg <= blk_out;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_block_out = out_blk_reg;

    // A new result only appears right after a block executed.
    `ASSERT_SAME(a_result_from_block, $rose(out_valid_reg), $past(exec_blk), "result without block")
    // Input side only stalls when the input stage is holding a transaction.
    `ASSERT_SAME(a_stall_needs_item, !s_ready, in_valid_reg && !exec, "spurious input stall")
    // Lane keys change only when a transaction executes.
    `ASSERT_NEXT(a_keys_hold, !exec, $stable(keys), "lane keys changed while idle")
    // A taken result with no block behind it leaves the result stage empty.
    `ASSERT_NEXT(a_result_drains, out_valid_reg && m_ready && !exec_blk, !out_valid_reg,
                 "result repeated")

endmodule
